/* rtl/core/mcv_pkg.sv */
// package for the map cursor and viewport controller: constants, rom and helpers
`default_nettype none
package mcv_pkg;

  localparam int WindowWidthDef  = 128;
  localparam int WindowHeightDef = 160;
  localparam int ZoomLevelsDef   = 6;

  localparam int LevelW   = 3;
  localparam int PixW     = 14;
  localparam int CoordW   = 32;
  localparam int DvdW     = 47;   // |delta| (33 bits) times limit (14 bits)
  localparam int DvsW     = 17;   // bounding box span or pixel limit
  localparam int InDataW  = 104;
  localparam int OutDataW = 144;

  localparam logic [LevelW-1:0] RomLast = 3'd5;
  localparam logic [LevelW-1:0] LevelRst = 3'd2;

  typedef enum logic [2:0] {
    CMD_ZOOM_IN    = 3'd0,
    CMD_ZOOM_OUT   = 3'd1,
    CMD_APPLY_ZOOM = 3'd2,
    CMD_CURSOR_BY  = 3'd3,
    CMD_CURSOR_TO  = 3'd4,
    CMD_WIN_PIXEL  = 3'd5,
    CMD_WIN_LONLAT = 3'd6,
    CMD_STATUS     = 3'd7
  } cmd_t;

  typedef struct packed {
    logic signed [CoordW-1:0] north;
    logic signed [CoordW-1:0] west;
    logic signed [CoordW-1:0] south;
    logic signed [CoordW-1:0] east;
  } box_t;

  // bounding box per applied level, levels past the last entry use the last
  function automatic box_t rom_box(input logic [LevelW-1:0] idx);
    box_t b;
    unique case (idx)
      3'd0:    b = '{32'sd5364463, -32'sd11373047, 32'sd5343572, -32'sd11337891};
      3'd1:    b = '{32'sd5364464, -32'sd11373047, 32'sd5343572, -32'sd11337891};
      3'd2:    b = '{32'sd5361858, -32'sd11368652, 32'sd5340953, -32'sd11333496};
      3'd3:    b = '{32'sd5360554, -32'sd11368652, 32'sd5339643, -32'sd11333496};
      3'd4:    b = '{32'sd5360554, -32'sd11367554, 32'sd5339643, -32'sd11332397};
      default: b = '{32'sd5360228, -32'sd11367554, 32'sd5339316, -32'sd11332397};
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/mcv_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module mcv_div import mcv_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [DvdW-1:0] dividend,
  input  wire logic [DvsW-1:0] divisor,
  output logic                 done,
  output logic [DvdW-1:0]      quotient
);

  localparam int CntW = $clog2(DvdW + 1);

  logic [DvsW-1:0] rem;
  logic [DvsW-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DvsW:0]   sh;
  logic            fits;

  assign sh   = {rem, quotient[DvdW-1]};
  assign fits = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DvdW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DvsW'(sh - {1'b0, dvs}) : sh[DvsW-1:0];
      quotient <= {quotient[DvdW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/map_cursor_viewport_controller_core.sv */
// top level: command sequencer, position state and shared multiply/divide unit
// zoom, window-to-pixel and status commands pass from accept through a prep state to the done state;
// conversion commands (apply zoom, cursor by/to, window to lon/lat) run two conversions, x/lon then
// y/lat, each a multiply, divider load, one divider step per quotient bit and write back; a new
// command is taken only once the last result has gone into the output register; reset: synchronous,
// levels to 2, cursor, lon/lat and window 0; a result not yet taken holds the next command in the done state
`default_nettype none
module map_cursor_viewport_controller_core import mcv_pkg::*; #(
  parameter int WINDOW_WIDTH  = WindowWidthDef,
  parameter int WINDOW_HEIGHT = WindowHeightDef,
  parameter int ZOOM_LEVELS   = ZoomLevelsDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // command[2:0], pos_x[18:3], pos_y[34:19], target_lon[66:35], target_lat[98:67]
  input  wire logic [InDataW-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // pending_level[2:0], active_level[5:3], cursor_px[19:6], cursor_py[33:20],
  // cursor_longitude[65:34], cursor_latitude[97:66], view_x[111:98], view_y[125:112],
  // visible[126], screen_x[133:127], screen_y[141:134], zero pad
  output logic [OutDataW-1:0]      m_tdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  // latched command
  cmd_t                     cmd;
  logic signed [15:0]       pos_x;
  logic signed [15:0]       pos_y;
  logic signed [CoordW-1:0] tgt_lon;
  logic signed [CoordW-1:0] tgt_lat;
  logic                     axis;    // 0 works on x/lon, 1 on y/lat

  // kept state
  logic [LevelW-1:0]        requested_level;
  logic [LevelW-1:0]        applied_level;
  logic [PixW-1:0]          cur_x;
  logic [PixW-1:0]          cur_y;
  logic signed [CoordW-1:0] cur_lon;
  logic signed [CoordW-1:0] cur_lat;
  logic [PixW-1:0]          win_x;
  logic [PixW-1:0]          win_y;

  // shared unit operands
  logic [DvdW-1:0]          div_dvd;
  logic [DvsW-1:0]          div_dvs;
  logic                     div_start;
  logic                     div_done;
  logic [DvdW-1:0]          div_q;
  logic                     neg;     // sign of the quotient

  // level dependent values
  logic [LevelW-1:0]        rom_idx;
  box_t                     box;
  logic [PixW-1:0]          lim;
  logic signed [15:0]       hi_wx;
  logic signed [15:0]       hi_wy;
  logic [PixW-1:0]          hi_x;
  logic [PixW-1:0]          hi_y;

  assign rom_idx = (applied_level > RomLast) ? RomLast : applied_level;
  assign box     = rom_box(rom_idx);
  assign lim     = PixW'((15'd512 << rom_idx) - 15'd1);
  assign hi_wx   = $signed({2'b00, lim}) - 16'(WINDOW_WIDTH);
  assign hi_wy   = $signed({2'b00, lim}) - 16'(WINDOW_HEIGHT);
  assign hi_x    = hi_wx[15] ? '0 : hi_wx[PixW-1:0];
  assign hi_y    = hi_wy[15] ? '0 : hi_wy[PixW-1:0];

  // clamp a signed pixel value to 0..hi
  function automatic logic [PixW-1:0] clamp18(input logic signed [17:0] v,
                                              input logic [PixW-1:0] hi);
    logic [PixW-1:0] r;
    if (v[17])                          r = '0;
    else if (v > $signed({4'b0, hi}))   r = hi;
    else                                r = v[PixW-1:0];
    return r;
  endfunction

  // cursor move target before the clamp
  logic signed [17:0] mv_x;
  logic signed [17:0] mv_y;
  always_comb begin
    if (cmd == CMD_CURSOR_BY) begin
      mv_x = $signed({4'b0, cur_x}) + 18'(pos_x);
      mv_y = $signed({4'b0, cur_y}) + 18'(pos_y);
    end else begin
      mv_x = 18'(pos_x);
      mv_y = 18'(pos_y);
    end
  end

  // multiply operands: degrees to pixels, or pixels to degrees
  logic                     to_px;
  logic signed [CoordW-1:0] src;
  logic signed [32:0]       delta;
  logic [32:0]              mag;
  logic [32:0]              mul_a;
  logic [DvsW-1:0]          mul_b;
  logic [DvsW-1:0]          span;
  logic [49:0]              prod;

  assign to_px = (cmd == CMD_APPLY_ZOOM) || (cmd == CMD_WIN_LONLAT);

  always_comb begin
    if (cmd == CMD_APPLY_ZOOM) src = axis ? cur_lat : cur_lon;
    else                       src = axis ? tgt_lat : tgt_lon;
    // latitude runs north to south, so its difference is taken from the north edge
    if (axis) begin
      delta = 33'(box.north) - 33'(src);
      span  = DvsW'(box.north - box.south);
    end else begin
      delta = 33'(src) - 33'(box.west);
      span  = DvsW'(box.east - box.west);
    end
    mag = delta[32] ? 33'(-delta) : 33'(delta);
    if (to_px) begin
      mul_a = mag;
      mul_b = DvsW'(lim);
    end else begin
      mul_a = 33'(axis ? cur_y : cur_x);
      mul_b = span;
    end
    prod = mul_a * mul_b;
  end

  // quotient clamped into a pixel range
  logic [PixW-1:0] q_hi;
  logic [PixW-1:0] q_px;
  always_comb begin
    if (cmd == CMD_WIN_LONLAT) q_hi = axis ? hi_y : hi_x;
    else                       q_hi = lim;
    if (neg && (div_q != '0))              q_px = '0;
    else if (div_q > DvdW'(q_hi))          q_px = q_hi;
    else                                   q_px = div_q[PixW-1:0];
  end

  mcv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // visibility and screen offset from the updated state
  logic [15:0] dx;
  logic [15:0] dy;
  logic        vis;
  assign dx  = {2'b00, cur_x} - {2'b00, win_x};
  assign dy  = {2'b00, cur_y} - {2'b00, win_y};
  assign vis = (win_x < cur_x) && ({2'b00, cur_x} < {2'b00, win_x} + 16'(WINDOW_WIDTH)) &&
               (win_y < cur_y) && ({2'b00, cur_y} < {2'b00, win_y} + 16'(WINDOW_HEIGHT));

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      div_start       <= 1'b0;
      m_tvalid        <= 1'b0;
      requested_level <= LevelRst;
      applied_level   <= LevelRst;
      cur_x           <= '0;
      cur_y           <= '0;
      cur_lon         <= '0;
      cur_lat         <= '0;
      win_x           <= '0;
      win_y           <= '0;
    end else begin
      div_start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_PREP;
        end
        S_PREP: begin
          state <= S_DONE;
          unique case (cmd)
            CMD_ZOOM_IN: begin
              if (requested_level < LevelW'(ZOOM_LEVELS - 1))
                requested_level <= requested_level + 1'b1;
            end
            CMD_ZOOM_OUT: begin
              if (requested_level != '0) requested_level <= requested_level - 1'b1;
            end
            CMD_APPLY_ZOOM: begin
              applied_level <= requested_level;
              state         <= S_MUL;
            end
            CMD_CURSOR_BY, CMD_CURSOR_TO: begin
              cur_x <= clamp18(mv_x, lim);
              cur_y <= clamp18(mv_y, lim);
              state <= S_MUL;
            end
            CMD_WIN_PIXEL: begin
              win_x <= clamp18(18'(pos_x), hi_x);
              win_y <= clamp18(18'(pos_y), hi_y);
            end
            CMD_WIN_LONLAT: state <= S_MUL;
            default: ;
          endcase
        end
        S_MUL: begin
          div_start <= 1'b1;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            unique case (cmd)
              CMD_APPLY_ZOOM: begin
                if (axis) cur_y <= q_px;
                else      cur_x <= q_px;
              end
              CMD_WIN_LONLAT: begin
                if (axis) win_y <= q_px;
                else      win_x <= q_px;
              end
              default: begin
                if (axis) cur_lat <= box.north - CoordW'(div_q);
                else      cur_lon <= box.west + CoordW'(div_q);
              end
            endcase
            state <= axis ? S_DONE : S_MUL;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      cmd     <= cmd_t'(s_tdata[2:0]);
      pos_x   <= s_tdata[18:3];
      pos_y   <= s_tdata[34:19];
      tgt_lon <= s_tdata[66:35];
      tgt_lat <= s_tdata[98:67];
      axis    <= 1'b0;
    end else if (state == S_DIV && div_done) begin
      axis <= 1'b1;
    end
    if (state == S_MUL) begin
      div_dvd <= prod[DvdW-1:0];
      div_dvs <= to_px ? span : DvsW'(lim);
      neg     <= to_px && delta[32];
    end
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00,
                  vis ? dy[7:0] : 8'd0,
                  vis ? dx[6:0] : 7'd0,
                  vis,
                  win_y, win_x,
                  cur_lat, cur_lon,
                  cur_y, cur_x,
                  applied_level, requested_level};
    end
  end

endmodule
`default_nettype wire

/* verif/map_cursor_viewport_controller_core_test.sv */
// testbench for the map cursor and viewport controller: directed and random commands checked against a predictor
`default_nettype none
module map_cursor_viewport_controller_core_test;
  import mcv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WinW = 128;
  localparam int WinH = 160;
  localparam int NumLevels = 6;
  localparam int RandomItems = 1330;
  localparam int CycleLimit = 2000000;
  localparam int TailItems = 150;  // no idling once this few commands remain

  // command item, lowest field last
  typedef struct packed {
    logic [4:0] pad;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [15:0] py;
    logic signed [15:0] px;
    cmd_t cmd;
  } command_item_t;

  // status item, lowest field last
  typedef struct packed {
    logic [1:0] pad;
    logic [7:0] scr_y;
    logic [6:0] scr_x;
    logic vis;
    logic [13:0] view_y;
    logic [13:0] view_x;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic [13:0] py;
    logic [13:0] px;
    logic [2:0] active;
    logic [2:0] pending;
  } status_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  map_cursor_viewport_controller_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bounding boxes per level: north, west, south, east in 1e-5 degrees
  longint box_n [6] = '{5364463, 5364464, 5361858, 5360554, 5360554, 5360228};
  longint box_w [6] = '{-11373047, -11373047, -11368652, -11368652, -11367554, -11367554};
  longint box_s [6] = '{5343572, 5343572, 5340953, 5339643, 5339643, 5339316};
  longint box_e [6] = '{-11337891, -11337891, -11333496, -11333496, -11332397, -11332397};

  // predicted block state
  int unsigned want_level, map_level;
  longint cur_x, cur_y, win_x, win_y;
  int cur_lon, cur_lat;

  command_item_t pending_cmds[$];
  status_item_t expected_status[$];
  int errors = 0;
  int checked = 0;
  int cycle = 0;
  int cmd_count[8];

  function automatic int unsigned box_idx();
    return (map_level < 6) ? map_level : 5;
  endfunction

  function automatic longint map_lim();
    return (longint'(512) << box_idx()) - 1;
  endfunction

  // truncating linear interpolation, exact in 64 bits
  function automatic longint lerp(longint v, longint lo, longint hi, longint olo, longint ohi);
    if (hi == lo) return olo;
    return (v - lo) * (ohi - olo) / (hi - lo) + olo;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    longint h;
    h = (hi < lo) ? lo : hi;
    if (v < lo) return lo;
    if (v > h) return h;
    return v;
  endfunction

  function automatic void move_cursor(longint x, longint y);
    int unsigned b;
    b = box_idx();
    cur_x = clip(x, 0, map_lim());
    cur_y = clip(y, 0, map_lim());
    cur_lon = int'(lerp(cur_x, 0, map_lim(), box_w[b], box_e[b]));
    cur_lat = int'(lerp(cur_y, 0, map_lim(), box_n[b], box_s[b]));
  endfunction

  function automatic void set_window(longint x, longint y);
    win_x = clip(x, 0, map_lim() - WinW);
    win_y = clip(y, 0, map_lim() - WinH);
  endfunction

  // apply one command to the predicted state and return the status it reports
  function automatic status_item_t run_command(command_item_t c);
    status_item_t r;
    int unsigned b;
    logic vis;
    b = box_idx();
    case (c.cmd)
      CMD_ZOOM_IN: if (want_level < NumLevels - 1) want_level++;
      CMD_ZOOM_OUT: if (want_level > 0) want_level--;
      CMD_APPLY_ZOOM: begin
        map_level = want_level;
        b = box_idx();
        cur_x = clip(lerp(cur_lon, box_w[b], box_e[b], 0, map_lim()), 0, map_lim());
        cur_y = clip(lerp(cur_lat, box_n[b], box_s[b], 0, map_lim()), 0, map_lim());
      end
      CMD_CURSOR_BY: move_cursor(cur_x + longint'(c.px), cur_y + longint'(c.py));
      CMD_CURSOR_TO: move_cursor(longint'(c.px), longint'(c.py));
      CMD_WIN_PIXEL: set_window(longint'(c.px), longint'(c.py));
      CMD_WIN_LONLAT: set_window(lerp(longint'(c.lon), box_w[b], box_e[b], 0, map_lim()),
                                 lerp(longint'(c.lat), box_n[b], box_s[b], 0, map_lim()));
      default: ;
    endcase
    vis = (win_x < cur_x) && (cur_x < win_x + WinW) && (win_y < cur_y) && (cur_y < win_y + WinH);
    r = '0;
    r.pending = want_level[2:0];
    r.active = map_level[2:0];
    r.px = cur_x[13:0];
    r.py = cur_y[13:0];
    r.lon = cur_lon;
    r.lat = cur_lat;
    r.view_x = win_x[13:0];
    r.view_y = win_y[13:0];
    r.vis = vis;
    r.scr_x = vis ? 7'(cur_x - win_x) : '0;
    r.scr_y = vis ? 8'(cur_y - win_y) : '0;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch on item %0d field %s: got %0d, expected %0d", checked, field, got, want);
  endtask

  function automatic command_item_t make_cmd(cmd_t c, int x, int y, int lon, int lat);
    command_item_t i;
    i = '0;
    i.cmd = c;
    i.px = 16'(x);
    i.py = 16'(y);
    i.lon = lon;
    i.lat = lat;
    return i;
  endfunction

  // random command, mostly with meaningful values and sometimes raw bits
  function automatic command_item_t random_cmd();
    command_item_t i;
    int unsigned pick;
    i = '0;
    i.px = 16'($urandom);
    i.py = 16'($urandom);
    i.lon = $urandom;
    i.lat = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 9) i.cmd = CMD_ZOOM_IN;
    else if (pick < 18) i.cmd = CMD_ZOOM_OUT;
    else if (pick < 30) i.cmd = CMD_APPLY_ZOOM;
    else if (pick < 50) i.cmd = CMD_CURSOR_BY;
    else if (pick < 68) i.cmd = CMD_CURSOR_TO;
    else if (pick < 82) i.cmd = CMD_WIN_PIXEL;
    else if (pick < 94) i.cmd = CMD_WIN_LONLAT;
    else i.cmd = CMD_STATUS;
    if ($urandom_range(0, 9) != 0) begin
      if (i.cmd == CMD_CURSOR_BY) begin
        i.px = 16'($urandom_range(0, 400) - 200);
        i.py = 16'($urandom_range(0, 400) - 200);
      end else begin
        i.px = 16'($urandom_range(0, 17000) - 300);
        i.py = 16'($urandom_range(0, 17000) - 300);
      end
      i.lon = -11373047 + int'($urandom_range(0, 50000)) - 5000;
      i.lat = 5339316 + int'($urandom_range(0, 30000)) - 5000;
    end
    return i;
  endfunction

  // predict at each accepted command
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      command_item_t c;
      c = command_item_t'(s_tdata);
      cmd_count[c.cmd]++;
      expected_status.push_back(run_command(c));
    end
  end

  // command driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() > TailItems && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 7);
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_cmds.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // status receiver with random stalls and one long hold-off
  int recv_gap = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && checked == 300) begin
      hold_done <= 1'b1;
      hold_cycles <= 400;
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 1'b0;
    end else if (pending_cmds.size() > TailItems && $urandom_range(0, 5) == 0) begin
      recv_gap <= $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // status checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      status_item_t got, want;
      got = status_item_t'(m_tdata);
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected status item", 1, 0);
      end else begin
        want = expected_status.pop_front();
        if (got.pending !== want.pending) report_mismatch("pending_level", got.pending, want.pending);
        if (got.active !== want.active) report_mismatch("active_level", got.active, want.active);
        if (got.px !== want.px) report_mismatch("cursor_px", got.px, want.px);
        if (got.py !== want.py) report_mismatch("cursor_py", got.py, want.py);
        if (got.lon !== want.lon) report_mismatch("cursor_longitude", got.lon, want.lon);
        if (got.lat !== want.lat) report_mismatch("cursor_latitude", got.lat, want.lat);
        if (got.view_x !== want.view_x) report_mismatch("view_x", got.view_x, want.view_x);
        if (got.view_y !== want.view_y) report_mismatch("view_y", got.view_y, want.view_y);
        if (got.vis !== want.vis) report_mismatch("visible", got.vis, want.vis);
        if (got.scr_x !== want.scr_x) report_mismatch("screen_x", got.scr_x, want.scr_x);
        if (got.scr_y !== want.scr_y) report_mismatch("screen_y", got.scr_y, want.scr_y);
      end
      checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles", cycle);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    want_level = 2;
    map_level = 2;
    cur_x = 0;
    cur_y = 0;
    cur_lon = 0;
    cur_lat = 0;
    win_x = 0;
    win_y = 0;
    // directed: status at reset, cursor and window clamps, zoom saturation both ways, apply at the extremes
    pending_cmds.push_back(make_cmd(CMD_STATUS, -1, -1, -1, -1));
    pending_cmds.push_back(make_cmd(CMD_CURSOR_TO, 32767, 32767, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CURSOR_TO, -32768, -32768, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CURSOR_TO, 300, 400, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_WIN_PIXEL, 250, 300, 0, 0));
    for (int k = 0; k < 4; k++) pending_cmds.push_back(make_cmd(CMD_ZOOM_IN, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_APPLY_ZOOM, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CURSOR_BY, 32767, 32767, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_WIN_PIXEL, 32767, 32767, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CURSOR_BY, -32768, -32768, 0, 0));
    for (int k = 0; k < 6; k++) pending_cmds.push_back(make_cmd(CMD_ZOOM_OUT, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_WIN_LONLAT, 0, 0, 32'h7fffffff, 32'h80000000));
    pending_cmds.push_back(make_cmd(CMD_WIN_LONLAT, 0, 0, 32'h80000000, 32'h7fffffff));
    pending_cmds.push_back(make_cmd(CMD_APPLY_ZOOM, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CURSOR_TO, 100, 120, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_WIN_LONLAT, 0, 0, -11370000, 5360000));
    pending_cmds.push_back(make_cmd(CMD_WIN_PIXEL, -32768, -1, 0, 0));
    for (int k = 0; k < RandomItems; k++) pending_cmds.push_back(random_cmd());
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    @(posedge clk);
    while (s_tvalid) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("checked %0d status items in %0d cycles", checked, cycle);
    $display("commands by code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", cmd_count[0], cmd_count[1],
             cmd_count[2], cmd_count[3], cmd_count[4], cmd_count[5], cmd_count[6], cmd_count[7]);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/core/mcv_pkg.sv
rtl/core/mcv_div.sv
rtl/core/map_cursor_viewport_controller_core.sv
verif/map_cursor_viewport_controller_core_test.sv
